@@ sv/obt_pkg.sv @@
// Package: shared types and constants for the order book table.
`default_nettype none
package obt_pkg;
	localparam int MaxOrdersDefault = 256;
	localparam int MaxListedDefault = 64;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_CLOSE = 2'd1;
	localparam logic [1:0] CMD_LIST  = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_OVER     = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOIDS    = 3'd4;

	localparam int EntryW = 32 + 64 + 32;

	// controller -> datapath commands
	typedef struct packed {
		logic load;        // capture request, clear scan pointer
		logic step;        // advance scan pointer
		logic rd;          // issue read at scan pointer
		logic mark_free;   // remember current slot as free
		logic wr_add;      // write new order to free slot
		logic wr_close;    // write reduced order back
		logic hold;        // capture current list match
		logic emit;        // load output register
		logic emit_held;   // output from held list match
		logic [2:0] emit_status;
		logic emit_zero;   // zero id/price/remaining
		logic emit_last;
	} obt_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic scan_done;   // slot under evaluation is the last slot
		logic live;        // registered slot is live
		logic id_hit;
		logic price_hit;
		logic over;
		logic ids_out;
		logic have_free;
		logic out_busy;
	} obt_sts_t;
endpackage
`default_nettype wire

@@ sv/order_book_table.sv @@
// Top level of the order book table.
// Each request scans the order slots one at a time through a single-port slot memory,
// reading each slot and then evaluating it: an add or a list with no early stop scans
// every slot, a close stops at its hit, and a list ends once MAX_LISTED matches are
// found. A list waits at a match while it holds an earlier match and the previous
// result is still held at the output, and any request waits to emit its final
// result for the same reason.
// A new request is taken only when the previous one has emitted its final result.
`default_nettype none
module order_book_table #(
	parameter int MAX_ORDERS = obt_pkg::MaxOrdersDefault,
	parameter int MAX_LISTED = obt_pkg::MaxListedDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [63:0] price,
	input  wire logic [31:0] quantity,
	input  wire logic [31:0] order_id,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [2:0]  status,
	output      logic [31:0] result_id,
	output      logic [63:0] result_price,
	output      logic [31:0] remaining,
	output      logic [39:0] total_quantity,
	output      logic        last
);
	obt_pkg::obt_cmd_t cmd_c;
	obt_pkg::obt_sts_t sts;

	obt_ctrl #(.MaxListed(MAX_LISTED)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .sts(sts), .cmd_c(cmd_c)
	);

	obt_datapath #(.MaxOrders(MAX_ORDERS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd_c(cmd_c), .sts(sts),
		.price(price), .quantity(quantity), .order_id(order_id),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.result_id(result_id), .result_price(result_price), .remaining(remaining),
		.total_quantity(total_quantity), .last(last)
	);
endmodule
`default_nettype wire

@@ sv/obt_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module obt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output      logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

@@ sv/obt_datapath.sv @@
// Datapath: slot memory, live bits, scan pointer, id counter, total, output register.
`default_nettype none
module obt_datapath #(
	parameter int MaxOrders = obt_pkg::MaxOrdersDefault
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire obt_pkg::obt_cmd_t cmd_c,
	output      obt_pkg::obt_sts_t sts,
	input  wire logic [63:0]       price,
	input  wire logic [31:0]       quantity,
	input  wire logic [31:0]       order_id,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      logic [2:0]        status,
	output      logic [31:0]       result_id,
	output      logic [63:0]       result_price,
	output      logic [31:0]       remaining,
	output      logic [39:0]       total_quantity,
	output      logic              last
);
	localparam int AW = $clog2(MaxOrders);

	logic [63:0] price_q;
	logic [31:0] qty_q, oid_q, last_id_q;
	logic [39:0] total_q;
	logic [AW-1:0] ptr_q, slot_q, free_q;
	logic have_free_q;
	logic [MaxOrders-1:0] live_q;
	logic live_rd_q;
	logic [31:0] hold_id_q, hold_left_q;

	logic [AW-1:0] addr;
	logic we;
	logic [obt_pkg::EntryW-1:0] wdata, rdata;
	logic [31:0] r_id, r_left, new_left;
	logic [63:0] r_price;

	assign {r_id, r_price, r_left} = rdata;
	assign new_left = r_left - qty_q;
	// outside a read or an add write the address stays on the current slot so its data holds
	assign addr = (cmd_c.wr_add) ? free_q : (cmd_c.rd ? ptr_q : slot_q);
	assign we = cmd_c.wr_add | cmd_c.wr_close;
	assign wdata = cmd_c.wr_add ? {last_id_q + 32'd1, price_q, qty_q}
	                            : {r_id, r_price, new_left};

	obt_ram #(.Width(obt_pkg::EntryW), .Depth(MaxOrders)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign sts.scan_done = (slot_q == AW'(MaxOrders - 1));
	assign sts.live      = live_rd_q;
	assign sts.id_hit    = (r_id == oid_q);
	assign sts.price_hit = (r_price == price_q);
	assign sts.over      = (qty_q > r_left);
	assign sts.ids_out   = (last_id_q == 32'hFFFF_FFFF);
	assign sts.have_free = have_free_q;
	assign sts.out_busy  = out_valid & ~out_ready;

	// request capture, scan pointer and book state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0; slot_q <= '0; free_q <= '0; have_free_q <= 1'b0;
			live_q <= '0; live_rd_q <= 1'b0; last_id_q <= '0; total_q <= '0;
			price_q <= '0; qty_q <= '0; oid_q <= '0;
			hold_id_q <= '0; hold_left_q <= '0;
		end else begin
			if (cmd_c.load) begin
				ptr_q <= '0; have_free_q <= 1'b0;
				price_q <= price; qty_q <= quantity; oid_q <= order_id;
			end else if (cmd_c.step) begin
				ptr_q <= ptr_q + AW'(1);
			end
			if (cmd_c.rd) begin
				slot_q <= ptr_q;
				live_rd_q <= live_q[ptr_q];
			end
			if (cmd_c.mark_free) begin
				free_q <= slot_q; have_free_q <= 1'b1;
			end
			// list match held until it is known whether it is the last one
			if (cmd_c.hold) begin
				hold_id_q <= r_id; hold_left_q <= r_left;
			end
			if (cmd_c.wr_add) begin
				live_q[free_q] <= 1'b1;
				last_id_q <= last_id_q + 32'd1;
				total_q <= total_q + {8'd0, qty_q};
			end
			if (cmd_c.wr_close) begin
				total_q <= total_q - {8'd0, qty_q};
				if (new_left == 32'd0) live_q[slot_q] <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd_c.emit) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd_c.emit) begin
			status <= cmd_c.emit_status;
			last <= cmd_c.emit_last;
			if (cmd_c.emit_zero) begin
				result_id <= '0; result_price <= '0; remaining <= '0;
			end else if (cmd_c.emit_held) begin
				result_id <= hold_id_q; result_price <= price_q;
				remaining <= hold_left_q;
			end else if (cmd_c.wr_add) begin
				result_id <= last_id_q + 32'd1; result_price <= price_q;
				remaining <= qty_q;
			end else begin
				result_id <= r_id; result_price <= r_price;
				remaining <= cmd_c.wr_close ? new_left : r_left;
			end
			if (cmd_c.wr_add) total_quantity <= total_q + {8'd0, qty_q};
			else if (cmd_c.wr_close) total_quantity <= total_q - {8'd0, qty_q};
			else total_quantity <= total_q;
		end
	end
endmodule
`default_nettype wire

@@ sv/obt_ctrl.sv @@
// Controller: sequences the slot scan for add, close and list requests.
`default_nettype none
module obt_ctrl #(
	parameter int MaxListed = obt_pkg::MaxListedDefault
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire logic [1:0]        cmd,
	input  wire obt_pkg::obt_sts_t sts,
	output      obt_pkg::obt_cmd_t cmd_c
);
	localparam int CW = $clog2(MaxListed + 1);

	typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_HOLD, S_FINAL} state_t;
	state_t state_q;
	logic [1:0] op_q;
	logic [CW-1:0] cnt_q;
	// list: a match is held and emitted once the next one, the scan end or the list limit is known
	logic pend_q;
	logic pend_ok;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd_c = '0;
		pend_ok = 1'b0;
		case (state_q)
			S_IDLE:  cmd_c.load = in_valid & (cmd != obt_pkg::CMD_RSVD);
			S_READ: begin
				cmd_c.rd = 1'b1;
				cmd_c.step = 1'b1;
			end
			S_EVAL: begin
				case (op_q)
					obt_pkg::CMD_ADD: begin
						cmd_c.mark_free = ~sts.live & ~sts.have_free;
					end
					obt_pkg::CMD_CLOSE: begin
						if (sts.live && sts.id_hit && !sts.out_busy) begin
							cmd_c.emit = 1'b1;
							cmd_c.emit_last = 1'b1;
							cmd_c.wr_close = ~sts.over;
							cmd_c.emit_status = sts.over ? obt_pkg::ST_OVER : obt_pkg::ST_OK;
						end
					end
					obt_pkg::CMD_LIST: begin
						pend_ok = sts.live & sts.price_hit;
						// new match: send the held one (not last) and hold this one
						if (pend_ok && (!pend_q || !sts.out_busy)) begin
							cmd_c.hold = 1'b1;
							if (pend_q) begin
								cmd_c.emit = 1'b1;
								cmd_c.emit_held = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			S_FINAL: begin
				if (!sts.out_busy) begin
					cmd_c.emit = 1'b1;
					cmd_c.emit_last = 1'b1;
					case (op_q)
						obt_pkg::CMD_ADD: begin
							if (!sts.have_free) begin
								cmd_c.emit_status = obt_pkg::ST_FULL;
								cmd_c.emit_zero = 1'b1;
							end else if (sts.ids_out) begin
								cmd_c.emit_status = obt_pkg::ST_NOIDS;
								cmd_c.emit_zero = 1'b1;
							end else begin
								cmd_c.wr_add = 1'b1;
							end
						end
						default: begin
							cmd_c.emit_status = obt_pkg::ST_NOTFOUND;
							cmd_c.emit_zero = 1'b1;
						end
					endcase
				end
			end
			S_HOLD: begin
				// emit the held list match as the final result
				if (!sts.out_busy) begin
					cmd_c.emit = 1'b1;
					cmd_c.emit_held = 1'b1;
					cmd_c.emit_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// state and registered control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; op_q <= obt_pkg::CMD_ADD; cnt_q <= '0; pend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (cmd_c.load) begin
					op_q <= cmd; cnt_q <= '0; pend_q <= 1'b0;
					state_q <= S_READ;
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					if (op_q == obt_pkg::CMD_LIST) begin
						if (cmd_c.hold) begin
							cnt_q <= cnt_q + CW'(1);
							pend_q <= 1'b1;
							if (sts.scan_done || cnt_q == CW'(MaxListed - 1))
								state_q <= S_HOLD;
							else state_q <= S_READ;
						end else if (!pend_ok) begin
							if (sts.scan_done) begin
								if (pend_q) state_q <= S_HOLD;
								else state_q <= S_FINAL;
							end else state_q <= S_READ;
						end
					end else if (cmd_c.emit) state_q <= S_IDLE;
					else if (op_q == obt_pkg::CMD_CLOSE && sts.live && sts.id_hit)
						state_q <= S_EVAL;
					else if (sts.scan_done) state_q <= S_FINAL;
					else state_q <= S_READ;
				end
				S_HOLD: if (cmd_c.emit) state_q <= S_IDLE;
				S_FINAL: if (cmd_c.emit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_emit_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_c.emit |-> state_q != S_IDLE) else $error("emit in idle");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_c.wr_add && cmd_c.wr_close)) else $error("double write");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MaxListed)) else $error("list count overflow");
	a_held_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_c.emit_held |-> pend_q) else $error("held match emitted without one");
endmodule
`default_nettype wire
